// ----- hw/rtl/ffd_pkg.sv -----
// shared types and constants for the feedback fractional delay
`timescale 1ns / 1ps
`default_nettype none
package ffd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int LEN_CFG_W  = 17;
    localparam int COEF_W     = 18;
    localparam int GAIN_W     = 18;
    localparam int DELAY_W    = 24;
    localparam int FRAC_W     = 8;
    localparam int MUL_B_W    = 19;
    localparam int DEN_W      = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERPOLATE_ON = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ON      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEF    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ON       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_ON        = 3'd5;

    localparam logic [LEN_CFG_W-1:0] LINE_LENGTH_RST = 17'd65536;
    localparam logic [COEF_W-1:0]    FILTER_COEF_RST = 18'd32768;
    localparam logic [DEN_W-1:0]     COEF_ONE        = 19'd65536;

    localparam logic signed [GAIN_W-1:0] GAIN_LIMIT = 18'sd64880;
    localparam int FLUSH_LSB = 8;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLAMP,
        ST_RDA,
        ST_RDB,
        ST_DIFF,
        ST_INTERP,
        ST_LPMUL,
        ST_LPSUM,
        ST_LPDIV,
        ST_FBMUL,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ffd_mul.sv -----
// shared registered signed multiplier
`timescale 1ns / 1ps
`default_nettype none
module ffd_mul #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                     aclk,
    input  wire logic signed [SAMPLE_BITS:0]              a_in,
    input  wire logic signed [ffd_pkg::MUL_B_W-1:0]       b_in,
    output logic signed [SAMPLE_BITS+ffd_pkg::MUL_B_W:0]  p_reg
);
    import ffd_pkg::*;

    always_ff @(posedge aclk) begin
        p_reg <= a_in * b_in;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/ffd_div.sv -----
// iterative floor divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ffd_div #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    start,
    input  wire logic signed [SAMPLE_BITS+19:0]          num,
    input  wire logic [ffd_pkg::DEN_W-1:0]               den,
    output logic                                         done_reg,
    output logic signed [SAMPLE_BITS-1:0]                quot
);
    import ffd_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int PW = S + 20;
    localparam int CW = $clog2(S + 1);

    logic [PW-1:0] rem_reg, rem_next;
    logic [PW-1:0] dsh_reg, dsh_next;
    logic [S-1:0]  q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_next;
    logic [PW-1:0] dsh_init;

    // offset the numerator so the quotient is never negative
    assign dsh_init = PW'(den) << (S - 1);

    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = $unsigned(num) + dsh_init;
            dsh_next  = dsh_init;
            q_next    = '0;
            cnt_next  = CW'(S);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= dsh_reg) begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[S-2:0], 1'b1};
            end else begin
                q_next   = {q_reg[S-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    // remove the offset again
    assign quot = $signed({~q_reg[S-1], q_reg[S-2:0]});

endmodule
`default_nettype wire

// ----- hw/rtl/feedback_fractional_delay.sv -----
// top level: delay memory, sequencer and datapath of the feedback delay
// one item at a time; steps after accept: clamp (not in hold), reads RDA and RDB, then
//   interpolation and lowpass if enabled (divider: one quotient bit per cycle), then feedback
//   multiply and write (not in hold), then done; a stalled result holds the done step, and
//   the shared multiplier and the single memory read port set the step count
// reset: a clearing pass zeroes the delay memory, no item taken meanwhile
`timescale 1ns / 1ps
`default_nettype none
module feedback_fractional_delay #(
    parameter int DEPTH       = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]         s_sample_in,
    input  wire logic [ffd_pkg::DELAY_W-1:0]           s_delay_samples,
    input  wire logic signed [ffd_pkg::GAIN_W-1:0]     s_feedback_gain,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [SAMPLE_BITS-1:0]              m_sample_out,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [ffd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [ffd_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import ffd_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int AW = $clog2(DEPTH);
    localparam int LW = AW + 1;
    localparam int XW = (LW + FRAC_W > DELAY_W) ? LW + FRAC_W : DELAY_W;
    localparam int PW = S + 20;
    localparam logic signed [S+2:0] SAT_HI = (S+3)'((64'sd1 <<< (S - 1)) - 64'sd1);
    localparam logic signed [S+2:0] SAT_LO = -SAT_HI - (S+3)'(1);
    localparam logic signed [S+1:0] FLUSH_HI = (S+2)'(FLUSH_LSB);
    localparam logic signed [S+1:0] FLUSH_LO = -FLUSH_HI;

    // configuration
    logic [LEN_CFG_W-1:0] line_length_reg;
    logic                 interpolate_on_reg;
    logic                 filter_on_reg;
    logic [COEF_W-1:0]    filter_coef_reg;
    logic                 limit_on_reg;
    logic                 hold_on_reg;

    // control state
    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]        wp_reg, wp_next;
    logic signed [S-1:0]  lp_reg, lp_next;
    logic                 m_valid_reg, m_valid_next;

    // item payload
    logic signed [S-1:0]      x_reg, x_next;
    logic [DELAY_W-1:0]       delay_reg, delay_next;
    logic signed [GAIN_W-1:0] gain_reg, gain_next;
    logic [LW-1:0]            w_reg, w_next;
    logic [LW-1:0]            idel_reg, idel_next;
    logic [FRAC_W-1:0]        frac_reg, frac_next;
    logic [LW-1:0]            ia_reg, ia_next;
    logic signed [S-1:0]      a_reg, a_next;
    logic signed [S-1:0]      y_reg, y_next;
    logic signed [S-1:0]      out_reg, out_next;

    // memory
    logic [S-1:0]   mem [DEPTH];
    logic [S-1:0]   rd_data_reg;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [S-1:0]   wr_data;

    // datapath helpers
    logic [31:0]                  ll32;
    logic [LW-1:0]                len;
    logic [LW-1:0]                w_eff;
    logic [LW-1:0]                w_inc;
    logic [XW-1:0]                dx, dlim, dcl;
    logic [LW-1:0]                ia;
    logic [LW-1:0]                ib;
    logic signed [GAIN_W-1:0]     gain_lim;
    logic signed [S:0]            mul_a;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [S+MUL_B_W:0]    prod;
    logic signed [PW-1:0]         lp_num;
    logic [DEN_W-1:0]             lp_den;
    logic                         div_start;
    logic                         div_done;
    logic signed [S-1:0]          div_q;
    logic signed [S+1:0]          fb;
    logic signed [S+2:0]          wsum;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = out_reg;
    assign cfg_ready    = 1'b1;

    // effective length and write position
    assign ll32 = 32'(line_length_reg);
    always_comb begin
        if (line_length_reg == '0) begin
            len = LW'(1);
        end else if (ll32 > 32'(DEPTH)) begin
            len = LW'(DEPTH);
        end else begin
            len = LW'(ll32);
        end
    end

    assign w_eff = ({1'b0, wp_reg} >= len) ? '0 : {1'b0, wp_reg};
    assign w_inc = ((w_reg + LW'(1)) == len) ? '0 : w_reg + LW'(1);

    // delay clamp
    assign dx   = XW'(delay_reg);
    assign dlim = XW'(len) << FRAC_W;
    assign dcl  = (dx >= dlim) ? (XW'(len - LW'(1)) << FRAC_W) : dx;

    // read positions
    assign ia = (w_reg >= idel_reg) ? w_reg - idel_reg : w_reg + len - idel_reg;
    assign ib = (ia_reg == '0) ? len - LW'(1) : ia_reg - LW'(1);

    always_comb begin
        gain_lim = s_feedback_gain;
        if (limit_on_reg) begin
            if (s_feedback_gain > GAIN_LIMIT) begin
                gain_lim = GAIN_LIMIT;
            end else if (s_feedback_gain < -GAIN_LIMIT) begin
                gain_lim = -GAIN_LIMIT;
            end
        end
    end

    // multiplier operands
    always_comb begin
        case (state_reg)
            ST_DIFF: begin
                mul_a = (S+1)'($signed(rd_data_reg)) - (S+1)'(a_reg);
                mul_b = $signed({{(MUL_B_W-FRAC_W){1'b0}}, frac_reg});
            end
            ST_LPMUL: begin
                mul_a = (S+1)'(lp_reg);
                mul_b = $signed({1'b0, filter_coef_reg});
            end
            default: begin
                mul_a = (S+1)'(y_reg);
                mul_b = MUL_B_W'(gain_reg);
            end
        endcase
    end

    ffd_mul #(
        .SAMPLE_BITS(S)
    ) u_mul (
        .aclk  (aclk),
        .a_in  (mul_a),
        .b_in  (mul_b),
        .p_reg (prod)
    );

    assign lp_num = (PW'(y_reg) <<< 16) + PW'(prod);
    assign lp_den = COEF_ONE + DEN_W'(filter_coef_reg);

    ffd_div #(
        .SAMPLE_BITS(S)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (lp_num),
        .den      (lp_den),
        .done_reg (div_done),
        .quot     (div_q)
    );

    // feedback and saturated write value
    always_comb begin
        fb = (S+2)'(prod >>> 16);
        if (fb <= FLUSH_HI && fb >= FLUSH_LO) begin
            fb = '0;
        end
        wsum = (S+3)'(x_reg) + (S+3)'(fb);
        if (wsum > SAT_HI) begin
            wsum = SAT_HI;
        end else if (wsum < SAT_LO) begin
            wsum = SAT_LO;
        end
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        wp_next      = wp_reg;
        lp_next      = lp_reg;
        m_valid_next = m_valid_reg;
        x_next       = x_reg;
        delay_next   = delay_reg;
        gain_next    = gain_reg;
        w_next       = w_reg;
        idel_next    = idel_reg;
        frac_next    = frac_reg;
        ia_next      = ia_reg;
        a_next       = a_reg;
        y_next       = y_reg;
        out_next     = out_reg;
        rd_addr      = ia[AW-1:0];
        wr_en        = 1'b0;
        wr_addr      = w_reg[AW-1:0];
        wr_data      = S'(wsum);
        div_start    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    x_next     = s_sample_in;
                    delay_next = s_delay_samples;
                    gain_next  = gain_lim;
                    w_next     = w_eff;
                    state_next = hold_on_reg ? ST_RDA : ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                idel_next  = LW'(dcl >> FRAC_W);
                frac_next  = dcl[FRAC_W-1:0];
                state_next = ST_RDA;
            end
            ST_RDA: begin
                rd_addr    = hold_on_reg ? w_reg[AW-1:0] : ia[AW-1:0];
                ia_next    = ia;
                state_next = ST_RDB;
            end
            ST_RDB: begin
                rd_addr = ib[AW-1:0];
                a_next  = $signed(rd_data_reg);
                y_next  = $signed(rd_data_reg);
                if (hold_on_reg) begin
                    state_next = ST_DONE;
                end else if (interpolate_on_reg) begin
                    state_next = ST_DIFF;
                end else if (filter_on_reg) begin
                    state_next = ST_LPMUL;
                end else begin
                    state_next = ST_FBMUL;
                end
            end
            ST_DIFF: begin
                state_next = ST_INTERP;
            end
            ST_INTERP: begin
                y_next     = S'((S+MUL_B_W+1)'(a_reg) + (prod >>> FRAC_W));
                state_next = filter_on_reg ? ST_LPMUL : ST_FBMUL;
            end
            ST_LPMUL: begin
                state_next = ST_LPSUM;
            end
            ST_LPSUM: begin
                div_start  = 1'b1;
                state_next = ST_LPDIV;
            end
            ST_LPDIV: begin
                if (div_done) begin
                    y_next     = div_q;
                    lp_next    = div_q;
                    state_next = ST_FBMUL;
                end
            end
            ST_FBMUL: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                wr_en      = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = y_reg;
                    m_valid_next = 1'b1;
                    wp_next      = w_inc[AW-1:0];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            wp_reg      <= '0;
            lp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            wp_reg      <= wp_next;
            lp_reg      <= lp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        delay_reg <= delay_next;
        gain_reg  <= gain_next;
        w_reg     <= w_next;
        idel_reg  <= idel_next;
        frac_reg  <= frac_next;
        ia_reg    <= ia_next;
        a_reg     <= a_next;
        y_reg     <= y_next;
        out_reg   <= out_next;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg    <= LINE_LENGTH_RST;
            interpolate_on_reg <= 1'b1;
            filter_on_reg      <= 1'b0;
            filter_coef_reg    <= FILTER_COEF_RST;
            limit_on_reg       <= 1'b0;
            hold_on_reg        <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LINE_LENGTH:    line_length_reg    <= cfg_data[LEN_CFG_W-1:0];
                CFG_INTERPOLATE_ON: interpolate_on_reg <= cfg_data[0];
                CFG_FILTER_ON:      filter_on_reg      <= cfg_data[0];
                CFG_FILTER_COEF:    filter_coef_reg    <= cfg_data[COEF_W-1:0];
                CFG_LIMIT_ON:       limit_on_reg       <= cfg_data[0];
                CFG_HOLD_ON:        hold_on_reg        <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // delay memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    a_no_write_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_CLEAR || !hold_on_reg))
        else $error("delay memory written while holding");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the done step");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg != ST_IDLE)
        else $error("item accepted but sequencer stayed idle");

    a_div_only_with_filter: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (filter_on_reg && !hold_on_reg))
        else $error("divider started without the lowpass");

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// testbench for the feedback fractional delay: directed and random items checked by a predictor
`timescale 1ns / 1ps
module tb_top;
    import ffd_pkg::*;

    localparam int DEPTH        = 65536;
    localparam int SAMPLE_BITS  = 24;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam longint LIMIT_CYCLES = 3000000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX  = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN  = 24'sh800000;
    localparam logic signed [GAIN_W-1:0]      GAIN_MAX = 18'sh1FFFF;
    localparam logic signed [GAIN_W-1:0]      GAIN_MIN = 18'sh20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample_in = '0;
    logic [DELAY_W-1:0] s_delay_samples = '0;
    logic signed [GAIN_W-1:0] s_feedback_gain = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] m_sample_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    int echo_mem [DEPTH];
    int unsigned echo_wpos = 0;
    longint lp_state = 0;
    logic [LEN_CFG_W-1:0] cfg_len = LINE_LENGTH_RST;
    logic cfg_interp = 1'b1;
    logic cfg_filter = 1'b0;
    logic [COEF_W-1:0] cfg_coef = FILTER_COEF_RST;
    logic cfg_limit = 1'b0;
    logic cfg_hold = 1'b0;

    logic signed [SAMPLE_BITS-1:0] expected_out_q [$];
    int err_count = 0;
    bit gaps_on = 1'b1;
    int stall_left = 0;
    longint cycle_count = 0;

    feedback_fractional_delay #(
        .DEPTH(DEPTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_sample_in(s_sample_in),
        .s_delay_samples(s_delay_samples),
        .s_feedback_gain(s_feedback_gain),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_sample_out(m_sample_out),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic longint div_floor(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        return q;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] predict_echo(
        logic signed [SAMPLE_BITS-1:0] smp,
        logic [DELAY_W-1:0] dly,
        logic signed [GAIN_W-1:0] gn
    );
        longint len, w, d, idelay, frac, ia, ib, a, b, y, g, f, x, c, lim;
        len = 64'(cfg_len);
        if (len < 1) len = 1;
        if (len > DEPTH) len = DEPTH;
        w = 64'(echo_wpos);
        if (w >= len) w = 0;
        if (cfg_hold) begin
            y = 64'(echo_mem[w]);
        end else begin
            x = 64'(smp);
            d = 64'(dly);
            g = 64'(gn);
            if (d >= len * 256) d = (len - 1) * 256;
            idelay = d >> 8;
            frac = d & 255;
            ia = (w >= idelay) ? w - idelay : w + len - idelay;
            a = 64'(echo_mem[ia]);
            y = a;
            if (cfg_interp) begin
                ib = (ia == 0) ? len - 1 : ia - 1;
                b = 64'(echo_mem[ib]);
                y = a + div_floor(frac * (b - a), 256);
            end
            if (cfg_filter) begin
                c = 64'(cfg_coef);
                y = div_floor(y * 65536 + lp_state * c, 65536 + c);
                lp_state = y;
            end
            if (cfg_limit) begin
                lim = 64'(GAIN_LIMIT);
                if (g > lim) g = lim;
                if (g < -lim) g = -lim;
            end
            f = div_floor(y * g, 65536);
            if (f <= FLUSH_LSB && f >= -FLUSH_LSB) f = 0;
            x = x + f;
            if (x > 64'(SMP_MAX)) x = 64'(SMP_MAX);
            if (x < 64'(SMP_MIN)) x = 64'(SMP_MIN);
            echo_mem[w] = int'(x);
        end
        w = w + 1;
        if (w >= len) w = 0;
        echo_wpos = 32'(w);
        return y[SAMPLE_BITS-1:0];
    endfunction

    task automatic send_item(
        input logic signed [SAMPLE_BITS-1:0] smp,
        input logic [DELAY_W-1:0] dly,
        input logic signed [GAIN_W-1:0] gn
    );
        int gap;
        s_valid <= 1'b1;
        s_sample_in <= smp;
        s_delay_samples <= dly;
        s_feedback_gain <= gn;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        expected_out_q.push_back(predict_echo(smp, dly, gn));
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        case (idx)
            CFG_LINE_LENGTH:    cfg_len = val[LEN_CFG_W-1:0];
            CFG_INTERPOLATE_ON: cfg_interp = val[0];
            CFG_FILTER_ON:      cfg_filter = val[0];
            CFG_FILTER_COEF:    cfg_coef = val[COEF_W-1:0];
            CFG_LIMIT_ON:       cfg_limit = val[0];
            CFG_HOLD_ON:        cfg_hold = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_out_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_default_extremes();
        send_item(SMP_MAX, 24'h000000, 18'sd0);
        send_item(SMP_MIN, 24'h000180, GAIN_MAX);
        send_item(24'sd0, 24'hFFFFFF, GAIN_MIN);
        send_item(24'sd1000, 24'h0000FF, 18'sd65536);
    endtask

    task automatic test_single_entry_line();
        wait_idle();
        // zero length behaves as one entry
        write_reg(CFG_LINE_LENGTH, 18'd0);
        send_item(SMP_MAX, 24'h0001FF, GAIN_MAX);
        send_item(SMP_MIN, 24'h123456, GAIN_MIN);
        wait_idle();
        write_reg(CFG_LINE_LENGTH, 18'd1);
        send_item(SMP_MIN, 24'h000000, GAIN_MAX);
        send_item(SMP_MAX, 24'hFFFFFF, GAIN_MIN);
    endtask

    task automatic test_feedback_paths();
        wait_idle();
        write_reg(CFG_LINE_LENGTH, 18'd4);
        write_reg(CFG_INTERPOLATE_ON, 18'd0);
        write_reg(CFG_LIMIT_ON, 18'd1);
        write_reg(CFG_FILTER_ON, 18'd1);
        write_reg(CFG_FILTER_COEF, 18'h3FFFF);
        send_item(SMP_MAX, 24'h000100, GAIN_MAX);
        send_item(SMP_MIN, 24'h000300, GAIN_MIN);
        send_item(24'sd0, 24'h000200, GAIN_MAX);
        wait_idle();
        write_reg(CFG_FILTER_COEF, 18'd0);
        write_reg(CFG_LIMIT_ON, 18'd0);
        write_reg(CFG_FILTER_ON, 18'd0);
        // fill the ring with small values, then probe the flush threshold
        repeat (4) send_item(24'sd7, 24'h000000, 18'sd0);
        send_item(24'sd3, 24'h000300, 18'sd65536);
        send_item(24'sd3, 24'h000300, GAIN_MAX);
        send_item(24'sd3, 24'h000300, GAIN_MIN);
    endtask

    task automatic test_hold_replay();
        wait_idle();
        write_reg(CFG_HOLD_ON, 18'd1);
        send_item(SMP_MIN, 24'hFFFFFF, GAIN_MAX);
        send_item(SMP_MAX, 24'h000000, GAIN_MIN);
        wait_idle();
        write_reg(CFG_HOLD_ON, 18'd0);
    endtask

    task automatic test_length_edges();
        wait_idle();
        write_reg(CFG_UNUSED_LO, 18'h3FFFF);
        write_reg(CFG_UNUSED_HI, 18'h00001);
        // beyond the memory depth, clamps to full depth
        write_reg(CFG_LINE_LENGTH, 18'h3FFFF);
        write_reg(CFG_INTERPOLATE_ON, 18'd1);
        send_item(SMP_MAX, 24'hFFFFFF, GAIN_MAX);
        repeat (3) send_item(24'sd12345, 24'h000280, 18'sd40000);
        wait_idle();
        // write position now lies past the shortened line
        write_reg(CFG_LINE_LENGTH, 18'd2);
        send_item(-24'sd777, 24'h000180, GAIN_MIN);
    endtask

    task automatic test_random_phases();
        int done_items, phase_items, hold_at, i, r, span;
        logic [31:0] junk, bits;
        logic [LEN_CFG_W-1:0] lenv;
        logic [COEF_W-1:0] coefv;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic [DELAY_W-1:0] dly;
        logic signed [GAIN_W-1:0] gn;
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            wait_idle();
            junk = ($urandom_range(0, 1) != 0) ? $urandom : 32'd0;
            bits = $urandom;
            r = $urandom_range(0, 99);
            if (r < 50) lenv = LEN_CFG_W'($urandom_range(2, 64));
            else if (r < 65) lenv = LEN_CFG_W'($urandom_range(65, 4096));
            else if (r < 75) lenv = LEN_CFG_W'(1);
            else if (r < 80) lenv = '0;
            else if (r < 90) lenv = LEN_CFG_W'(DEPTH);
            else lenv = LEN_CFG_W'($urandom_range(DEPTH + 1, 131071));
            span = (lenv == 0) ? 1 : ((lenv > DEPTH) ? DEPTH : int'(lenv));
            r = $urandom_range(0, 99);
            if (r < 30) coefv = '0;
            else if (r < 50) coefv = 18'h3FFFF;
            else coefv = COEF_W'($urandom_range(0, 262143));
            write_reg(CFG_LINE_LENGTH, {junk[17], lenv});
            write_reg(CFG_INTERPOLATE_ON, {junk[17:1], bits[0]});
            write_reg(CFG_FILTER_ON, {junk[17:1], bits[1]});
            write_reg(CFG_FILTER_COEF, coefv);
            write_reg(CFG_LIMIT_ON, {junk[17:1], bits[2]});
            write_reg(CFG_HOLD_ON, {junk[17:1], ($urandom_range(0, 99) < 15) ? 1'b1 : 1'b0});
            if ($urandom_range(0, 4) == 0) begin
                write_reg(bits[3] ? CFG_UNUSED_HI : CFG_UNUSED_LO, CFG_DATA_W'($urandom));
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            phase_items = $urandom_range(40, 160);
            hold_at = $urandom_range(0, phase_items - 1);
            for (i = 0; i < phase_items; i++) begin
                if (i == hold_at) wait_idle();
                r = $urandom_range(0, 99);
                if (r < 50) smp = SAMPLE_BITS'($urandom);
                else if (r < 80) smp = SAMPLE_BITS'($urandom_range(0, 2000) - 1000);
                else if (r < 90) smp = SMP_MAX;
                else if (r < 95) smp = SMP_MIN;
                else smp = '0;
                r = $urandom_range(0, 99);
                if (r < 60) dly = DELAY_W'($urandom_range(0, span * 256 - 1));
                else if (r < 80) dly = DELAY_W'($urandom);
                else if (r < 90) dly = DELAY_W'($urandom_range(0, span - 1) << 8);
                else dly = DELAY_W'(($urandom_range(0, span - 1) << 8) | 8'hFF);
                r = $urandom_range(0, 99);
                if (r < 40) gn = GAIN_W'($urandom);
                else if (r < 80) gn = GAIN_W'($urandom_range(0, 140000) - 70000);
                else begin
                    case ($urandom_range(0, 4))
                        0: gn = GAIN_MAX;
                        1: gn = GAIN_MIN;
                        2: gn = GAIN_LIMIT;
                        3: gn = -GAIN_LIMIT;
                        default: gn = '0;
                    endcase
                end
                send_item(smp, dly, gn);
            end
            done_items += phase_items;
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            m_ready <= (stall_left == 0);
        end
    end

    always @(posedge aclk) begin : check_out
        logic signed [SAMPLE_BITS-1:0] want;
        if (m_valid && m_ready) begin
            if (expected_out_q.size() == 0) begin
                if (err_count < 20) begin
                    $display("%0t unexpected item: sample_out expected none actual %0d",
                             $time, m_sample_out);
                end
                err_count++;
            end else begin
                want = expected_out_q.pop_front();
                if (m_sample_out !== want) begin
                    if (err_count < 20) begin
                        $display("%0t sample_out mismatch: expected %0d actual %0d",
                                 $time, want, m_sample_out);
                    end
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d items outstanding",
                     cycle_count, expected_out_q.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_extremes();
        test_single_entry_line();
        test_feedback_paths();
        test_hold_replay();
        test_length_edges();
        test_random_phases();
        wait_idle();
        if (err_count == 0 && expected_out_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
